>>> sv/sorted_insertion_list_macros.svh
// Assertion macros used by the sorted insertion list back end.
`ifndef SORTED_INSERTION_LIST_MACROS_SVH
`define SORTED_INSERTION_LIST_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SIL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SIL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`endif

>>> sv/sil_pkg.sv
package sil_pkg;

    // Default number of table entries.
    localparam int SIL_DEPTH = 16;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Operation codes as they arrive on the input channel.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One decoded item waiting in the queue between front and back.
    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    // Queue-to-back control group.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

endpackage

>>> sv/sil_front.sv
module sil_front
    import sil_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic signed [VALUE_W-1:0]  s_value,
    output queue_out_t                 q_out,
    input  logic                       q_pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      in_item;

    // Classify the incoming beat into an operation code.
    always_comb begin
        in_item.value = s_value;
        unique case (s_func)
            2'd0:    in_item.op = OP_APPEND;
            2'd1:    in_item.op = OP_INSERT;
            2'd2:    in_item.op = OP_CLEAR;
            default: in_item.op = OP_DUMP;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;

    // Two-entry queue toward the back end.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = slot_reg[rd_ptr_reg];

endmodule

>>> sv/sil_back.sv
`include "sorted_insertion_list_macros.svh"

module sil_back
    import sil_pkg::*;
#(
    parameter int DEPTH = SIL_DEPTH
)
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  queue_out_t                 q_in,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [VALUE_W-1:0]  m_entry_value,
    output logic [1:0]                 m_status,
    output logic [COUNT_W-1:0]         m_entry_count,
    output logic                       m_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic signed [VALUE_W-1:0] cells_reg [DEPTH];

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t                   out_status_reg, out_status_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;
    logic                      out_last_reg, out_last_next;

    logic                      out_free;
    logic                      full;
    logic                      is_insert;
    logic                      is_add;
    logic                      ins_en;
    logic                      rot_en;
    logic                      head_first;
    logic [DEPTH-1:0]          hit;
    logic [DEPTH-1:0]          at;
    logic [DEPTH-1:0]          at_prev;

    assign out_free  = !out_valid_reg || m_ready;
    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign is_insert = (q_in.item.op == OP_INSERT);
    assign is_add    = (q_in.item.op == OP_APPEND) || is_insert;

    // Position search: head test, then per-cell hit flags from one onward.
    assign head_first = (fill_reg == '0) ||
                        (is_insert && (cells_reg[0] > q_in.item.value));

    for (genvar i = 0; i < DEPTH; i++) begin : g_search
        if (i == 0) begin : g_head
            assign hit[i]     = 1'b0;
            assign at[i]      = head_first;
            assign at_prev[i] = 1'b0;
        end else begin : g_rest
            assign hit[i] = (CNT_W'(i) == fill_reg) ||
                            (is_insert && (CNT_W'(i) < fill_reg) &&
                             (cells_reg[i] >= q_in.item.value));
            assign at[i]      = at[i-1] | hit[i];
            assign at_prev[i] = at[i-1];
        end
    end

    // Compare-and-shift cells: load at the insert point, shift behind it,
    // or rotate the filled part left by one during a dump.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [VALUE_W-1:0] shift_src;
        logic signed [VALUE_W-1:0] up_src;
        logic signed [VALUE_W-1:0] rot_src;

        if (i == 0) begin : g_first
            assign shift_src = cells_reg[i];
        end else begin : g_mid
            assign shift_src = cells_reg[i-1];
        end
        if (i == DEPTH - 1) begin : g_end
            assign up_src = cells_reg[i];
        end else begin : g_up
            assign up_src = cells_reg[i+1];
        end
        assign rot_src = (CNT_W'(i + 1) == fill_reg) ? cells_reg[0] : up_src;

        always_ff @(posedge aclk) begin
            if (ins_en) begin
                if (at[i] && !at_prev[i]) begin
                    cells_reg[i] <= q_in.item.value;
                end else if (at_prev[i]) begin
                    cells_reg[i] <= shift_src;
                end
            end else if (rot_en) begin
                cells_reg[i] <= rot_src;
            end
        end
    end

    // Sequencer: one queued op at a time, dump beats one per cycle unless stalled.
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        rem_next        = rem_reg;
        q_pop           = 1'b0;
        ins_en          = 1'b0;
        rot_en          = 1'b0;
        out_valid_next  = out_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (q_in.valid && out_free) begin
                    q_pop           = 1'b1;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                    case (q_in.item.op) inside
                        OP_APPEND, OP_INSERT: begin
                            if (full) begin
                                out_status_next = ST_FULL;
                            end else begin
                                ins_en    = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            fill_next = '0;
                        end
                        default: begin
                            if (fill_reg == '0) begin
                                out_status_next = ST_EMPTY;
                            end else begin
                                rot_en         = 1'b1;
                                out_value_next = cells_reg[0];
                                out_last_next  = (fill_reg == CNT_W'(1));
                                rem_next       = fill_reg - CNT_W'(1);
                                if (fill_reg != CNT_W'(1)) begin
                                    state_next = S_DUMP;
                                end
                            end
                        end
                    endcase
                    out_count_next = fill_next;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    rot_en          = 1'b1;
                    out_valid_next  = 1'b1;
                    out_value_next  = cells_reg[0];
                    out_status_next = ST_OK;
                    out_count_next  = fill_reg;
                    out_last_next   = (rem_reg == CNT_W'(1));
                    rem_next        = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_entry_value = out_value_reg;
    assign m_status      = out_status_reg;
    assign m_entry_count = COUNT_W'(out_count_reg);
    assign m_last        = out_last_reg;

    // The fill count never passes the table size.
    `SIL_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CNT_W'(DEPTH))
    // A dump in progress has entries left.
    `SIL_ASSERT_IMP(a_dump_rem_nz, aclk, aresetn, state_reg == S_DUMP, rem_reg != '0)
    // A dump in progress never owes more than the table holds.
    `SIL_ASSERT_IMP(a_dump_rem_lt, aclk, aresetn, state_reg == S_DUMP, rem_reg < fill_reg)
    // A dropped append or insert leaves the fill count alone.
    `SIL_ASSERT_NXT(a_full_drop, aclk, aresetn, q_pop && full && is_add, $stable(fill_reg))
    // Nothing leaves the queue while a dump is under way.
    `SIL_ASSERT_IMP(a_no_pop_dump, aclk, aresetn, state_reg == S_DUMP, !q_pop)

endmodule

>>> sv/sorted_insertion_list.sv
// Sorted insertion list: a table of up to DEPTH signed 32-bit entries.
// Input channel (s_valid/s_ready): s_func selects append, ordered insert,
// clear or dump; s_value carries the value for the two insert operations.
// Result channel (m_valid/m_ready): each beat carries m_entry_value,
// m_status (ok, full, empty), m_entry_count and m_last, which marks the
// final beat caused by one input beat.
// Append, insert and clear give one beat each; an append or insert into a
// full table is dropped and reported as full. Dump gives one beat per entry,
// or one empty beat when the table holds nothing.
// Timing: an input beat reaches the back end through a two-entry queue,
// and its result is held in the output register. The back end takes one
// operation per cycle while the receiver is ready; a dump holds it until its
// last entry is out, one entry per cycle, as the cell row rotates under the output register.
// A full queue drops s_ready; a stalled receiver holds the output register
// and the back end, and the queue keeps taking beats until it fills.
// Reset (aresetn low, synchronous) empties the table and the queue.
module sorted_insertion_list
    import sil_pkg::*;
#(
    parameter int DEPTH = SIL_DEPTH
)
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic signed [VALUE_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [VALUE_W-1:0]  m_entry_value,
    output logic [1:0]                 m_status,
    output logic [COUNT_W-1:0]         m_entry_count,
    output logic                       m_last
);

    queue_out_t q_out;
    logic       q_pop;

    // Front end: decode and queue.
    sil_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .s_value (s_value),
        .q_out   (q_out),
        .q_pop   (q_pop)
    );

    // Back end: cell row, sequencer and output register.
    sil_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_in          (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_value (m_entry_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_last        (m_last)
    );

endmodule

>>> tb/sil_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the sorted insertion list, keeps its own copy of
// the table and compares every result beat with the oldest one due.
module sil_checker
    import sil_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [1:0]                s_func,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [VALUE_W-1:0] m_entry_value,
    input  logic [1:0]                m_status,
    input  logic [COUNT_W-1:0]        m_entry_count,
    input  logic                      m_last,
    output int                        mismatch_count,
    output int                        pending_beats
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry_value;
        status_t                   status;
        logic [COUNT_W-1:0]        entry_count;
        logic                      last;
    } list_beat_t;

    // Shadow copy of the table and the beats it still owes.
    logic signed [VALUE_W-1:0] list_mem [SIL_DEPTH];
    int                        list_fill = 0;
    list_beat_t                due_beats [$];

    // Queue one result beat; the count is the fill after the operation.
    function automatic void queue_beat(logic signed [VALUE_W-1:0] val, status_t st,
                                       logic last_mark);
        list_beat_t b;
        b.entry_value = val;
        b.status      = st;
        b.entry_count = COUNT_W'(list_fill);
        b.last        = last_mark;
        due_beats.push_back(b);
    endfunction

    // Apply one accepted operation to the shadow table.
    function automatic void apply_list_op(op_t op, logic signed [VALUE_W-1:0] val);
        int pos;
        int idx;
        case (op)
            OP_APPEND: begin
                if (list_fill >= SIL_DEPTH) begin
                    queue_beat('0, ST_FULL, 1'b1);
                end else begin
                    list_mem[list_fill] = val;
                    list_fill++;
                    queue_beat('0, ST_OK, 1'b1);
                end
            end
            OP_INSERT: begin
                if (list_fill >= SIL_DEPTH) begin
                    queue_beat('0, ST_FULL, 1'b1);
                end else begin
                    // The head is only displaced by a strictly smaller value;
                    // past the head the value goes in front of the first
                    // entry that is not smaller.
                    if (list_fill == 0 || list_mem[0] > val) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < list_fill && list_mem[pos] < val) pos++;
                    end
                    for (idx = list_fill; idx > pos; idx--) list_mem[idx] = list_mem[idx-1];
                    list_mem[pos] = val;
                    list_fill++;
                    queue_beat('0, ST_OK, 1'b1);
                end
            end
            OP_CLEAR: begin
                list_fill = 0;
                queue_beat('0, ST_OK, 1'b1);
            end
            default: begin
                if (list_fill == 0) begin
                    queue_beat('0, ST_EMPTY, 1'b1);
                end else begin
                    for (idx = 0; idx < list_fill; idx++)
                        queue_beat(list_mem[idx], ST_OK, idx == list_fill - 1);
                end
            end
        endcase
    endfunction

    // Count a failure and report the first few in detail.
    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
    endfunction

    // Inputs are predicted before outputs are compared at the same edge.
    always @(posedge aclk) begin
        list_beat_t want;
        if (!aresetn) begin
            list_fill = 0;
            due_beats.delete();
        end else begin
            if (s_valid && s_ready) apply_list_op(op_t'(s_func), s_value);
            if (m_valid && m_ready) begin
                if (due_beats.size() == 0) begin
                    flag_error($sformatf("unexpected result beat: value %0d status %0d count %0d last %0b",
                                         m_entry_value, m_status, m_entry_count, m_last));
                end else begin
                    want = due_beats.pop_front();
                    if (m_entry_value !== want.entry_value || m_status !== want.status ||
                        m_entry_count !== want.entry_count || m_last !== want.last) begin
                        flag_error($sformatf({"result beat mismatch: expected value %0d status %0d ",
                                              "count %0d last %0b, got value %0d status %0d ",
                                              "count %0d last %0b"},
                                             want.entry_value, want.status, want.entry_count,
                                             want.last, m_entry_value, m_status, m_entry_count,
                                             m_last));
                    end
                end
            end
        end
        pending_beats = due_beats.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sil_pkg::*;

    localparam int  RANDOM_ITEMS = 85;
    localparam int  MAX_IDLE     = 17;
    localparam int  HOLD_CYCLES  = 150;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  TIMEOUT_NS   = 2_000_000;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_func;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_entry_value;
    logic [1:0]                m_status;
    logic [COUNT_W-1:0]        m_entry_count;
    logic                      m_last;
    int                        mismatch_count;
    int                        pending_beats;

    // Shared between the sender and the receiver.
    bit idle_on   = 1'b1;
    bit hold_long = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sorted_insertion_list DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_value (m_entry_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_last        (m_last)
    );

    sil_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_value  (m_entry_value),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count),
        .m_last         (m_last),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    // Values mix small numbers, extremes and full-range words so that equal keys are common.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: begin
                v = $urandom_range(0, 8);
                v = v - 4;
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one input beat after a random gap and wait until it is taken.
    // With no gap, valid simply stays high for the next beat.
    task automatic send_beat(input op_t op, input logic signed [VALUE_W-1:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_func  <= 2'($urandom_range(0, 3));
            s_value <= $urandom;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= op;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: random stalls per beat, plus one long hold-off on request.
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Stimulus and verdict.
    initial begin
        int random_sent;
        int fill;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_func  <= OP_APPEND;
        s_value <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty dump, head and tail extremes, equal head, full table.
        send_beat(OP_DUMP, VAL_MAX);
        send_beat(OP_INSERT, '0);
        send_beat(OP_INSERT, VAL_MIN);
        send_beat(OP_INSERT, VAL_MAX);
        send_beat(OP_INSERT, VAL_MIN);
        send_beat(OP_APPEND, 5);
        send_beat(OP_INSERT, 3);
        send_beat(OP_DUMP, '0);
        repeat (9) send_beat(OP_APPEND, $urandom);
        send_beat(OP_INSERT, 7);
        send_beat(OP_APPEND, VAL_MIN);
        send_beat(OP_DUMP, '1);
        send_beat(OP_CLEAR, VAL_MAX);
        send_beat(OP_DUMP, VAL_MIN);
        send_beat(OP_APPEND, -1);
        send_beat(OP_INSERT, -1);
        send_beat(OP_DUMP, '0);

        // Back pressure: the receiver stops while a full table is dumped
        // repeatedly, so the input queue fills and stalls the sender.
        idle_on   = 1'b0;
        hold_long = 1'b1;
        send_beat(OP_CLEAR, '0);
        repeat (SIL_DEPTH) send_beat(OP_APPEND, pick_value());
        repeat (3) send_beat(OP_DUMP, pick_value());
        send_beat(OP_INSERT, pick_value());

        // Random: mostly clear, fill, dump episodes, with some noise between.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_beat(op_t'($urandom_range(0, 3)), pick_value());
                    random_sent++;
                end
            end else begin
                if ($urandom_range(0, 4) != 0) begin
                    send_beat(OP_CLEAR, pick_value());
                    random_sent++;
                end
                fill = $urandom_range(0, SIL_DEPTH + 2);
                repeat (fill) begin
                    send_beat(($urandom_range(0, 3) == 0) ? OP_APPEND : OP_INSERT,
                              pick_value());
                    random_sent++;
                end
                send_beat(OP_DUMP, pick_value());
                random_sent++;
            end
        end
        s_valid <= 1'b0;

        // Drain every owed beat, then leave room for any stray ones.
        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
